@@ rtl/hdu_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hdu_pkg: shared types and constants for the hash dedup unique id block
// Field widths, default capacity and the front-to-back command word.
// ---------------------------------------------------------------------------
package hdu_pkg;

  localparam int unsigned HashW     = 64;
  localparam int unsigned ElemW     = 8;
  localparam int unsigned IdW       = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned CapacityDefault = 256;

  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_e;

  // Command word handed from the front to the back through the queue
  typedef struct packed {
    logic             clear;
    logic [HashW-1:0] hash;
    logic [ElemW-1:0] elem;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_OUT
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/hdu_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hdu_in_if / hdu_out_if: valid/ready channels of the hash dedup block
// Source drives valid and payload, sink drives ready.
// ---------------------------------------------------------------------------
interface hdu_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] hash_value;
  logic [7:0]  element_index;
  modport source (output valid, mode, hash_value, element_index, input ready);
  modport sink   (input valid, mode, hash_value, element_index, output ready);
endinterface

interface hdu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] element_echo;
  logic       is_unique;
  logic [7:0] unique_id;
  logic       full_error;
  logic [8:0] unique_count;
  modport source (output valid, element_echo, is_unique, unique_id, full_error,
                  unique_count, input ready);
  modport sink   (input valid, element_echo, is_unique, unique_id, full_error,
                  unique_count, output ready);
endinterface
`default_nettype wire

@@ rtl/hdu_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hdu_ram: generic single-port RAM
// One write and one read per cycle at the same address, read data registered.
// ---------------------------------------------------------------------------
module hdu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/hdu_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hdu_front: input stage and two-entry command queue
// Packs accepted words into commands; the back end pops them on its own.
// ---------------------------------------------------------------------------
module hdu_front
  import hdu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hdu_in_if.sink    in_if,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_pop_i
);
  cmd_t       buf_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{clear: (in_if.mode == MODE_CLEAR),
                           hash: in_if.hash_value, elem: in_if.element_index};
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd2 && !cmd_pop_i) |=> cnt_q == 2'd2)
    else $error("queue lost a word");
endmodule
`default_nettype wire

@@ rtl/hdu_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hdu_back: key table search and update
// Scans stored keys one at a time through the RAM (read, then compare), appends new keys.
// ---------------------------------------------------------------------------
module hdu_back
  import hdu_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  hdu_out_if.source out_if
);
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              take;
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [HashW-1:0]  ram_rdata;
  logic              res_unique_d, res_err_d, res_unique_q, res_err_q;
  logic [CntW-1:0]   res_id_d, res_id_q;

  hdu_ram #(.Width(HashW), .Depth(Capacity)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(cmd_q.hash),
    .rdata_o(ram_rdata)
  );

  assign take = cmd_valid_i && (state_q == ST_IDLE);
  assign cmd_pop_o = take;

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    ram_we       = 1'b0;
    ram_addr     = idx_q[AddrW-1:0];
    res_unique_d = res_unique_q;
    res_err_d    = res_err_q;
    res_id_d     = res_id_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          idx_d = '0;
          res_unique_d = 1'b0;
          res_err_d = 1'b0;
          res_id_d = '0;
          if (cmd_i.clear) begin
            count_d = '0;
            state_d = ST_OUT;
          end else if (count_q == CntW'(Capacity)) begin
            res_err_d = 1'b1;
            state_d = ST_OUT;
          end else if (count_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (ram_rdata == cmd_q.hash) begin
          res_id_d = idx_q;
          state_d  = ST_OUT;
        end else if (idx_q + 1'b1 == count_q) begin
          state_d = ST_WRITE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_WRITE: begin
        ram_we       = 1'b1;
        ram_addr     = count_q[AddrW-1:0];
        res_id_d     = count_q;
        res_unique_d = 1'b1;
        count_d      = count_q + 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: if (out_if.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    idx_q        <= idx_d;
    res_unique_q <= res_unique_d;
    res_err_q    <= res_err_d;
    res_id_q     <= res_id_d;
  end

  // result word
  assign out_if.valid        = (state_q == ST_OUT);
  assign out_if.element_echo = cmd_q.elem;
  assign out_if.is_unique    = res_unique_q;
  assign out_if.unique_id    = IdW'(res_id_q);
  assign out_if.full_error   = res_err_q;
  assign out_if.unique_count = CountW'(count_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Capacity))
    else $error("count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_if.valid && out_if.is_unique) |-> !out_if.full_error)
    else $error("unique and error together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ram_we |=> count_q == $past(count_q) + 1'b1)
    else $error("append without count step");
endmodule
`default_nettype wire

@@ rtl/hash_dedup_unique_id_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hash_dedup_unique_id_core: hash deduplication with unique id assignment
// Input channel in_if carries mode, hash_value and element_index; output
// channel out_if returns one result word per input word.
// The front end takes words into a two-entry queue, so up to two words are
// accepted while the back end is busy or its result is stalled.
// The back end scans stored keys in RAM one at a time (RAM read state, then
// compare state) and appends a new key in a write state; a match ends the
// scan. A clear or a refused add goes straight to the result. The single
// RAM port and the sequential scan set the rate.
// Reset empties the queue and zeroes the key count; the RAM is not cleared,
// only entries below the count are ever compared.
// When the receiver holds ready low the result stays, the back end waits,
// and the input side keeps accepting until the queue is full.
// ---------------------------------------------------------------------------
module hash_dedup_unique_id_core
  import hdu_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hdu_in_if.sink    in_if,
  hdu_out_if.source out_if
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  hdu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  hdu_back #(.Capacity(Capacity)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_if     (out_if)
  );
endmodule
`default_nettype wire
